@@ hdl/mcbm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multicart bank mapper: event codes, mapper register
// struct, reset constants and the program bank function. No dependencies.
package mcbm_pkg;

    localparam int BankCountWidth = 9;
    localparam int BankWidth      = 8;

    localparam logic [BankCountWidth-1:0] BANK_COUNT_RESET = 9'd64;

    typedef enum logic [1:0] {
        FUNC_SELECT = 2'd0,
        FUNC_DATA   = 2'd1,
        FUNC_HARD   = 2'd2,
        FUNC_SOFT   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_CHR   = 2'd0,
        REG_INNER = 2'd1,
        REG_MODE  = 2'd2,
        REG_OUTER = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic [1:0] select;
        logic [1:0] chr_bank;
        logic [3:0] inner_bank;
        logic [1:0] size;
        logic [1:0] mode;
        logic [1:0] mirror;
        logic [5:0] outer_prg;
    } mapper_regs_t;

    typedef logic [3:0][BankWidth-1:0] slot_banks_t;

    // 16 KB bank for one half (h) of the program window, already as 8 KB bank
    function automatic logic [BankWidth-1:0] half_bank(
        input mapper_regs_t             regs,
        input logic [BankCountWidth-1:0] bank_count,
        input logic                     h
    );
        logic [BankCountWidth-1:0] count_m1;
        logic [BankWidth-1:0]      lim;
        logic [BankWidth-1:0]      outer;
        logic [1:0]                mode;
        logic [1:0]                size;
        logic [BankWidth-1:0]      cur;
        logic [BankWidth-1:0]      mask;
        logic [BankWidth-1:0]      bank;
        count_m1 = bank_count - 9'd1;
        lim      = count_m1[BankCountWidth-1:1];
        outer    = {1'b0, regs.outer_prg, 1'b0} & lim;
        mode     = regs.mode;
        size     = regs.size;
        if ((regs.mode ^ {1'b0, h}) == 2'd2) begin
            mode = 2'd0;
            size = 2'd0;
        end
        if (!mode[1]) begin
            cur = {3'd0, regs.inner_bank, h};
        end else begin
            cur = {4'd0, regs.inner_bank};
        end
        case (size)
            2'd0:    mask = 8'h01;
            2'd1:    mask = 8'h03;
            2'd2:    mask = 8'h07;
            default: mask = 8'h0F;
        endcase
        bank = ((cur ^ outer) & mask) ^ outer;
        return {bank[BankWidth-2:0], 1'b0};
    endfunction

    function automatic slot_banks_t reset_banks(
        input logic [BankCountWidth-1:0] bank_count
    );
        slot_banks_t banks;
        if (bank_count == 9'd2) begin
            banks = {8'd1, 8'd0, 8'd1, 8'd0};
        end else begin
            banks[0] = bank_count[BankWidth-1:0] - 8'd4;
            banks[1] = bank_count[BankWidth-1:0] - 8'd3;
            banks[2] = bank_count[BankWidth-1:0] - 8'd2;
            banks[3] = bank_count[BankWidth-1:0] - 8'd1;
        end
        return banks;
    endfunction

    localparam slot_banks_t SLOT_RESET = reset_banks(BANK_COUNT_RESET);

endpackage

@@ hdl/multicart_bank_mapper.sv @@
`timescale 1ns / 1ps
// Multicart bank mapper, top level: stream channels, bank count register,
// slot latches and output register. Depends on mcbm_pkg, mcbm_regs, mcbm_prg_map.
//
// Usage:
//   s_ channel: one transfer per CPU event. s_tuser is the event kind
//   (select write, data write, hard reset, soft reset), s_tdata the byte.
//   m_ channel: one transfer per event, the mapping in force after it.
//   cfg_wr_en/cfg_wr_data set the program ROM bank count (power of two);
//   write it only while no transfer is in flight.
//   The result is registered and is on m_ in the cycle after the input transfer.
//   Throughput: one event per cycle while m_ is not stalled; the register
//   update, slot mapping and output register form a single registered pass.
//   A stalled m_ side holds its result; s_tready drops only while a result
//   waits and m_tready is low.
//   Reset (aresetn low, synchronous): mapper registers clear, the bank
//   count returns to 64, the slots take the hard-reset mapping and the
//   output register empties.
module multicart_bank_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_data
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] slot0_bank, [15:8] slot1_bank,
                                   // [23:16] slot2_bank, [31:24] slot3_bank,
                                   // [36:32] chr_base_page, [38:37] mirroring
);
    import mcbm_pkg::*;

    logic [BankCountWidth-1:0] bank_count_reg;
    slot_banks_t               slots_reg;
    slot_banks_t               slots_next;
    slot_banks_t               mapped;
    mapper_regs_t              regs_next;
    logic                      m_tvalid_reg;
    logic [39:0]               m_tdata_reg;
    logic [39:0]               m_tdata_next;
    logic                      accept;
    func_t                     func;

    assign func     = func_t'(s_tuser);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mcbm_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .func       (func),
        .write_data (s_tdata),
        .regs_next  (regs_next)
    );

    mcbm_prg_map u_prg_map (
        .regs       (regs_next),
        .bank_count (bank_count_reg),
        .hard_reset (func == FUNC_HARD),
        .banks      (mapped)
    );

    always_comb begin
        case (func)
            FUNC_SOFT: slots_next = slots_reg;
            default:   slots_next = mapped;
        endcase
        m_tdata_next = {1'b0, regs_next.mirror, regs_next.chr_bank, 3'd0,
                        slots_next[3], slots_next[2], slots_next[1], slots_next[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_count_reg <= BANK_COUNT_RESET;
            slots_reg      <= SLOT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bank_count_reg <= cfg_wr_data;
            end
            if (accept) begin
                slots_reg    <= slots_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid
    ) else $error("accepted transfer produced no result");

    a_stall_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready
    ) else $error("input taken while result stalled");

    a_hard_reset_clears: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == FUNC_HARD) |=> (m_tdata[38:32] == 7'd0)
    ) else $error("hard reset left character or mirroring set");

endmodule

@@ hdl/mcbm_regs.sv @@
`timescale 1ns / 1ps
// Mapper register file: select, character, inner/outer bank, size, mode
// and mirroring, updated per accepted CPU event. Depends on mcbm_pkg.
module mcbm_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  mcbm_pkg::func_t       func,
    input  logic [7:0]            write_data,
    output mcbm_pkg::mapper_regs_t regs_next
);
    import mcbm_pkg::*;

    mapper_regs_t regs_reg;

    always_comb begin
        regs_next = regs_reg;
        unique case (func)
            FUNC_SELECT: begin
                regs_next.select = {write_data[7], write_data[0]};
            end
            FUNC_DATA: begin
                if (!regs_reg.select[1] && !regs_reg.mirror[1]) begin
                    regs_next.mirror[0] = write_data[4];
                end
                unique case (reg_sel_t'(regs_reg.select))
                    REG_CHR:   regs_next.chr_bank   = write_data[1:0];
                    REG_INNER: regs_next.inner_bank = write_data[3:0];
                    REG_MODE: begin
                        regs_next.size   = write_data[5:4];
                        regs_next.mode   = write_data[3:2];
                        regs_next.mirror = write_data[1:0];
                    end
                    default:   regs_next.outer_prg = write_data[5:0];
                endcase
            end
            FUNC_HARD: regs_next = '0;
            default:   regs_next = regs_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (accept) begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ hdl/mcbm_prg_map.sv @@
`timescale 1ns / 1ps
// Program slot mapping: four 8 KB banks from the mapper registers and the
// ROM bank count, or the hard-reset mapping. Depends on mcbm_pkg.
module mcbm_prg_map (
    input  mcbm_pkg::mapper_regs_t                regs,
    input  logic [mcbm_pkg::BankCountWidth-1:0]   bank_count,
    input  logic                                  hard_reset,
    output mcbm_pkg::slot_banks_t                 banks
);
    import mcbm_pkg::*;

    slot_banks_t mapped;

    for (genvar h = 0; h < 2; h++) begin : g_half
        logic [BankWidth-1:0] bank;
        assign bank              = half_bank(regs, bank_count, 1'(h));
        assign mapped[2*h]       = bank;
        assign mapped[2*h+1]     = {bank[BankWidth-1:1], 1'b1};
    end

    assign banks = hard_reset ? reset_banks(bank_count) : mapped;

endmodule
